FILE: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
// No dependencies; compiled before every other file in rtl/.
package deq_pkg;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DUMP       = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
	} deq_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item;
		logic               last;
		logic [5:0]         occupancy;
	} deq_out_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;       // request word taken this cycle
		logic load_item;  // capture read data into the result word
		logic next;       // step to the next dump entry and read it
	} deq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic last;
	} deq_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RESULT
	} deq_state_t;

endpackage

FILE: rtl/deq_dp.sv
// Datapath: entry memory, front index, count, dump cursor and result register.
// Depends on deq_pkg; driven by deq_ctrl through deq_cmd_t.
module deq_dp #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  deq_pkg::deq_in_t  req,
	input  deq_pkg::deq_cmd_t cmd,
	output deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_out_t rsp
);
	import deq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] WRAP     = SUM_W'(DEPTH);

	logic [31:0]      mem [DEPTH];
	logic [31:0]      rdata_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             dump_q;
	deq_out_t         rsp_q;

	logic             empty;
	logic             full;
	logic [CNT_W-1:0] off;
	logic [SUM_W-1:0] sum;
	logic [IDX_W-1:0] slot_addr;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] front_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [1:0]       st_code;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic             is_push;
	logic             is_fetch;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	assign is_push  = req.opcode inside {OP_PUSH_FRONT, OP_PUSH_BACK};
	assign is_fetch = req.opcode inside {OP_POP_FRONT, OP_POP_BACK, OP_DUMP};

	// slot(off) = (front + off) mod DEPTH; sum stays below 2*DEPTH
	always_comb begin
		off = '0;
		if (cmd.next) begin
			off = idx_q + CNT_W'(1);
		end else begin
			case (req.opcode)
				OP_PUSH_BACK: off = count_q;
				OP_POP_BACK:  off = count_q - CNT_W'(1);
				default:      off = '0;
			endcase
		end
		sum = SUM_W'(front_q) + SUM_W'(off);
		if (sum >= WRAP) begin
			slot_addr = IDX_W'(sum - WRAP);
		end else begin
			slot_addr = IDX_W'(sum);
		end
	end

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);

	always_comb begin
		front_nxt = front_q;
		cnt_nxt   = count_q;
		st_code   = STAT_OK;
		case (req.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					st_code = STAT_FULL;
				end else begin
					cnt_nxt = count_q + CNT_W'(1);
					if (req.opcode == OP_PUSH_FRONT) begin
						front_nxt = front_dec;
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					st_code = STAT_EMPTY;
				end else begin
					cnt_nxt = count_q - CNT_W'(1);
					if (req.opcode == OP_POP_FRONT) begin
						front_nxt = front_inc;
					end
				end
			end
			OP_DUMP: begin
				if (empty) begin
					st_code = STAT_EMPTY;
				end
			end
			default: st_code = STAT_OK;
		endcase
	end

	assign wr_en   = cmd.exec && is_push && !full;
	assign wr_addr = (req.opcode == OP_PUSH_FRONT) ? front_dec : slot_addr;
	assign rd_en   = (cmd.exec && is_fetch && !empty) || cmd.next;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[slot_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			dump_q  <= 1'b0;
		end else if (cmd.exec) begin
			front_q <= front_nxt;
			count_q <= cnt_nxt;
			idx_q   <= '0;
			dump_q  <= (req.opcode == OP_DUMP);
		end else if (cmd.next) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// result word; item filled in later for pops and dump entries
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.status    <= st_code;
			rsp_q.item      <= '0;
			rsp_q.last      <= 1'b1;
			rsp_q.occupancy <= 6'(cnt_nxt);
		end else if (cmd.load_item) begin
			rsp_q.item <= rdata_q;
			if (dump_q) begin
				rsp_q.last <= ((idx_q + CNT_W'(1)) == count_q);
			end
		end
	end

	assign rsp        = rsp_q;
	assign stat.empty = empty;
	assign stat.last  = rsp_q.last;

endmodule

FILE: rtl/deq_ctrl.sv
// Controller FSM: request/response handshakes and datapath sequencing.
// Depends on deq_pkg; drives deq_dp through deq_cmd_t.
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [2:0]         opcode,
	input  logic               rsp_ready,
	input  deq_pkg::deq_stat_t stat,
	output logic               req_ready,
	output logic               rsp_valid,
	output deq_pkg::deq_cmd_t  cmd
);
	import deq_pkg::*;

	deq_state_t state_q;
	deq_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		req_ready     = 1'b0;
		rsp_valid     = 1'b0;
		cmd.exec      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.next      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.exec = 1'b1;
					// pops and dumps on a non-empty queue need a memory read
					if ((opcode inside {OP_POP_FRONT, OP_POP_BACK, OP_DUMP}) && !stat.empty) begin
						state_nxt = ST_FETCH;
					end else begin
						state_nxt = ST_RESULT;
					end
				end
			end
			ST_FETCH: begin
				cmd.load_item = 1'b1;
				state_nxt     = ST_RESULT;
			end
			ST_RESULT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					if (stat.last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.next  = 1'b1;
						state_nxt = ST_FETCH;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/double_ended_queue_core.sv
// Bounded double-ended queue of 32-bit words in a DEPTH-entry ring buffer.
// Push, no-op and empty pop/dump: result word registered at accept and offered in
// the cycle after. Pop or dump on a non-empty queue: ST_FETCH, then ST_RESULT.
// A new request is taken only in ST_IDLE once the last result word is taken; each
// dump entry passes ST_FETCH then ST_RESULT (registered read, one-word result).
// Reset (arst_n low, asynchronous): queue empty, front index 0; memory not cleared.
module double_ended_queue_core #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  deq_pkg::deq_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::deq_out_t rsp
);
	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (req.opcode),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

FILE: tb/double_ended_queue_core_test.sv
// Self-checking bench for double_ended_queue_core: drives opcode/value words and
// checks every result word against an in-bench ring-buffer model.
// Depends on deq_pkg and the RTL under rtl/.
module double_ended_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int DEPTH = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 3000;
	localparam int TAIL_CYCLES = 10;
	localparam int PHASE_ITEMS = 57;
	localparam logic [2:0] OP_NOP_FIRST = 3'd5;
	localparam logic [2:0] OP_NOP_MID   = 3'd6;
	localparam logic [2:0] OP_NOP_LAST  = 3'd7;

	logic     clk;
	logic     arst_n;
	logic     req_valid = 1'b0;
	logic     req_ready;
	deq_in_t  req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	deq_out_t rsp;

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// stimulus and expectation stores
	deq_in_t  pending_words[$];
	deq_out_t expected_words[$];
	int       queued_count = 0;
	int       accepted_count = 0;
	int       error_count = 0;
	int       stuck_cycles = 0;
	int       gen_occupancy = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	bit       hold_request = 1'b0;
	int       hold_left = 0;
	logic     req_taken = 1'b0;

	// model of the deque
	logic [31:0] model_store [DEPTH];
	int unsigned model_front = 0;
	int unsigned model_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic deq_out_t make_word(logic [1:0] status, logic [31:0] item,
			logic last, int unsigned occ);
		deq_out_t w;
		w.status    = status;
		w.item      = item;
		w.last      = last;
		w.occupancy = 6'(occ);
		return w;
	endfunction

	task automatic apply_to_model(deq_in_t w);
		logic [31:0] got;
		case (w.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (model_count >= DEPTH) begin
					expected_words.push_back(make_word(STAT_FULL, '0, 1'b1, model_count));
				end else begin
					if (w.opcode == OP_PUSH_FRONT) begin
						model_front = (model_front + DEPTH - 1) % DEPTH;
						model_store[model_front] = w.value;
					end else begin
						model_store[(model_front + model_count) % DEPTH] = w.value;
					end
					model_count++;
					expected_words.push_back(make_word(STAT_OK, '0, 1'b1, model_count));
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (model_count == 0) begin
					expected_words.push_back(make_word(STAT_EMPTY, '0, 1'b1, 0));
				end else begin
					if (w.opcode == OP_POP_FRONT) begin
						got = model_store[model_front];
						model_front = (model_front + 1) % DEPTH;
					end else begin
						got = model_store[(model_front + model_count - 1) % DEPTH];
					end
					model_count--;
					expected_words.push_back(make_word(STAT_OK, got, 1'b1, model_count));
				end
			end
			OP_DUMP: begin
				if (model_count == 0) begin
					expected_words.push_back(make_word(STAT_EMPTY, '0, 1'b1, 0));
				end else begin
					for (int unsigned i = 0; i < model_count; i++) begin
						expected_words.push_back(make_word(STAT_OK,
							model_store[(model_front + i) % DEPTH],
							(i + 1 == model_count), model_count));
					end
				end
			end
			default: begin
				expected_words.push_back(make_word(STAT_OK, '0, 1'b1, model_count));
			end
		endcase
	endtask

	task automatic check_result(deq_out_t got);
		deq_out_t want;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected: status %0d item %0d last %0d occ %0d",
				got.status, got.item, got.last, got.occupancy);
			error_count++;
		end else begin
			want = expected_words.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				error_count++;
			end
			if (got.item !== want.item) begin
				$error("item: expected %0d, got %0d", want.item, got.item);
				error_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				error_count++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
				error_count++;
			end
		end
	endtask

	// sampling, prediction and watchdog
	always @(posedge clk) begin
		req_taken <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (req_valid && req_ready) begin
				apply_to_model(req);
				accepted_count++;
			end
			if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// request side: a word stays put until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req       <= pending_words.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side, with one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic add_word(logic [2:0] op, logic [31:0] val);
		deq_in_t w;
		w.opcode = op;
		w.value  = val;
		pending_words.push_back(w);
		queued_count++;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_occupancy < DEPTH) gen_occupancy++;
			OP_POP_FRONT, OP_POP_BACK:   if (gen_occupancy > 0) gen_occupancy--;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
	endfunction

	function automatic logic [2:0] pick_nop();
		return 3'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
	endfunction

	// runs of fills, drains, dumps and mixed traffic, with a little noise
	task automatic add_random(int n);
		int start;
		int kind;
		int reps;
		int r;
		start = queued_count;
		while (queued_count - start < n) begin
			kind = $urandom_range(0, 9);
			if (kind <= 1) begin
				while (gen_occupancy < DEPTH)
					add_word(pick_push(), pick_value());
				reps = $urandom_range(1, 2);
				repeat (reps) add_word(pick_push(), pick_value());
			end else if (kind <= 3) begin
				while (gen_occupancy > 0)
					add_word(pick_pop(), $urandom());
				add_word(pick_pop(), $urandom());
			end else if (kind == 4) begin
				add_word(OP_DUMP, $urandom());
			end else if (kind <= 8) begin
				reps = $urandom_range(4, 12);
				repeat (reps) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						add_word(pick_push(), pick_value());
					else if (r < 85)
						add_word(pick_pop(), $urandom());
					else if (r < 92)
						add_word(OP_DUMP, $urandom());
					else
						add_word(pick_nop(), $urandom());
				end
			end else begin
				add_word(pick_nop(), $urandom());
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_count != queued_count || expected_words.size() != 0);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, bit long_hold);
		@(posedge clk);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		add_random(PHASE_ITEMS);
		if (long_hold)
			hold_request = 1'b1;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		#3 arst_n = 1'b1;
		@(posedge clk);

		// directed: empty cases, extreme values, unused opcodes, both ends
		add_word(OP_DUMP, '0);
		add_word(OP_POP_FRONT, '0);
		add_word(OP_POP_BACK, '1);
		add_word(OP_PUSH_FRONT, 32'h7fff_ffff);
		add_word(OP_PUSH_BACK, 32'h8000_0000);
		add_word(OP_PUSH_FRONT, '0);
		add_word(OP_PUSH_BACK, '1);
		add_word(OP_NOP_FIRST, 32'h1234_5678);
		add_word(OP_NOP_MID, '1);
		add_word(OP_NOP_LAST, '0);
		add_word(OP_DUMP, '1);
		add_word(OP_POP_FRONT, '0);
		add_word(OP_POP_BACK, '0);
		add_word(OP_POP_FRONT, '0);
		add_word(OP_POP_BACK, '0);
		add_word(OP_POP_BACK, '0);
		add_word(OP_PUSH_BACK, 32'h5555_5555);
		add_word(OP_PUSH_FRONT, 32'haaaa_aaaa);
		add_word(OP_DUMP, '0);
		add_word(OP_POP_BACK, '0);
		add_word(OP_POP_FRONT, '0);
		wait_drained();

		run_phase(0, 0, 1'b0);
		run_phase(49, 0, 1'b0);
		run_phase(0, 49, 1'b1);
		run_phase(17, 17, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_dp.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_core.sv
tb/double_ended_queue_core_test.sv
